[hw/rtl/vmos_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vmos_pkg
// Shared types and constants of the operand stack: sizes, opcodes, status
// codes and controller states.
// ----------------------------------------------------------------------------
package vmos_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int VALUE_WIDTH = 64;

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W   = ((CNT_W > 9) ? CNT_W : 9) + 1;
    localparam int DEPTH_W = 9;
    localparam int DATA_W  = 64;
    localparam int POS_W   = 8;
    localparam int OP_W    = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_SWAP  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SWAP,
        ST_SWAP_WB,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/vm_operand_stack.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vm_operand_stack
// Operand stack of a bytecode interpreter: push, pop, peek, swap and clear,
// one result transaction per operation.
//
//   channel | ports                                   | dir
//   --------+-----------------------------------------+-----
//   s_      | s_valid s_ready s_opcode s_value         | in
//           | s_position                              |
//   m_      | m_valid m_ready m_data m_status m_depth  | out
//
// Push, clear, unused opcodes and every error are answered from the idle state.
// Pop and peek take one RAM read. Swap takes two reads, then two writes on
// the single RAM write port. One operation in flight at a time.
// The result register frees the input side; a stalled m_ready holds the
// controller in its response state. Reset empties the stack at once.
// ----------------------------------------------------------------------------
module vm_operand_stack
    import vmos_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [OP_W-1:0]    s_opcode,
    input  wire logic [DATA_W-1:0]  s_value,
    input  wire logic [POS_W-1:0]   s_position,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [DATA_W-1:0]  m_data,
    output logic      [1:0]         m_status,
    output logic      [DEPTH_W-1:0] m_depth
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       top_reg, top_next;
    logic [ADDR_W-1:0]      hi_reg, hi_next;
    logic [ADDR_W-1:0]      lo_reg, lo_next;
    logic [VALUE_WIDTH-1:0] hold_reg, hold_next;
    logic [DATA_W-1:0]      res_data_reg, res_data_next;
    status_t                res_status_reg, res_status_next;

    logic                   m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]      m_data_reg, m_data_next;
    status_t                m_status_reg, m_status_next;
    logic [DEPTH_W-1:0]     m_depth_reg, m_depth_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr_a;
    logic [ADDR_W-1:0]      ram_raddr_b;
    logic [VALUE_WIDTH-1:0] ram_rdata_a;
    logic [VALUE_WIDTH-1:0] ram_rdata_b;

    op_t                    op;
    logic                   accept;
    logic                   out_free;
    logic                   full;
    logic                   empty;
    logic                   peek_bad;
    logic                   swap_bad;
    logic [CMP_W-1:0]       top_ext;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       hi_ext;
    logic [ADDR_W-1:0]      pop_addr;
    logic [ADDR_W-1:0]      hi_addr;
    logic [ADDR_W-1:0]      lo_addr;

    logic                   fin_valid;
    logic [DATA_W-1:0]      fin_data;
    status_t                fin_status;

    vmos_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // decode against the current depth
    always_comb begin
        op       = op_t'(s_opcode);
        accept   = s_valid && s_ready;
        out_free = !m_valid_reg || m_ready;
        top_ext  = CMP_W'(top_reg);
        pos_ext  = CMP_W'(s_position);
        full     = (top_reg == CNT_W'(STACK_DEPTH));
        empty    = (top_reg == '0);
        peek_bad = (pos_ext >= top_ext);
        swap_bad = (top_ext < pos_ext + CMP_W'(2));
        hi_ext   = top_ext - CMP_W'(1) - pos_ext;
        pop_addr = ADDR_W'(top_ext - CMP_W'(1));
        hi_addr  = ADDR_W'(hi_ext);
        lo_addr  = ADDR_W'(hi_ext - CMP_W'(1));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (op == OP_POP && !empty) begin
                        state_next = ST_READ;
                    end else if (op == OP_PEEK && !peek_bad) begin
                        state_next = ST_READ;
                    end else if (op == OP_SWAP && !swap_bad) begin
                        state_next = ST_SWAP;
                    end else if (!out_free) begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_READ:    state_next = out_free ? ST_IDLE : ST_RESP;
            ST_SWAP:    state_next = ST_SWAP_WB;
            ST_SWAP_WB: state_next = out_free ? ST_IDLE : ST_RESP;
            ST_RESP:    state_next = out_free ? ST_IDLE : ST_RESP;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        top_next    = top_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        hold_next   = hold_reg;
        ram_we      = 1'b0;
        ram_waddr   = hi_reg;
        ram_wdata   = s_value[VALUE_WIDTH-1:0];
        ram_raddr_a = (op == OP_POP) ? pop_addr : hi_addr;
        ram_raddr_b = lo_addr;
        fin_valid   = 1'b0;
        fin_data    = '0;
        fin_status  = STS_OK;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    hi_next = hi_addr;
                    lo_next = lo_addr;
                    unique case (op)
                        OP_PUSH: begin
                            fin_valid = 1'b1;
                            if (full) begin
                                fin_status = STS_OVERFLOW;
                                top_next   = '0;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(top_reg);
                                top_next  = top_reg + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (empty) begin
                                fin_valid  = 1'b1;
                                fin_status = STS_UNDERFLOW;
                            end else begin
                                top_next = top_reg - CNT_W'(1);
                            end
                        end
                        OP_PEEK: begin
                            if (peek_bad) begin
                                fin_valid  = 1'b1;
                                fin_status = STS_UNDERFLOW;
                            end
                        end
                        OP_SWAP: begin
                            if (swap_bad) begin
                                fin_valid  = 1'b1;
                                fin_status = STS_UNDERFLOW;
                                top_next   = '0;
                            end
                        end
                        OP_CLEAR: begin
                            fin_valid = 1'b1;
                            top_next  = '0;
                        end
                        default: begin
                            fin_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                fin_valid = 1'b1;
                fin_data  = DATA_W'(ram_rdata_a);
            end
            ST_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = ram_rdata_b;
                hold_next = ram_rdata_a;
            end
            ST_SWAP_WB: begin
                ram_we    = 1'b1;
                ram_waddr = lo_reg;
                ram_wdata = hold_reg;
                fin_valid = 1'b1;
            end
            ST_RESP: begin
                fin_valid  = 1'b1;
                fin_data   = res_data_reg;
                fin_status = res_status_reg;
            end
            default: begin
            end
        endcase

        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        m_depth_next    = m_depth_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        if (fin_valid) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                m_data_next   = fin_data;
                m_status_next = fin_status;
                m_depth_next  = DEPTH_W'(top_next);
            end else begin
                res_data_next   = fin_data;
                res_status_next = fin_status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        hold_reg       <= hold_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
        m_depth_reg    <= m_depth_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;
    assign m_depth  = m_depth_reg;

    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond capacity");

    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE || state_reg == ST_SWAP ||
                    state_reg == ST_SWAP_WB))
        else $error("RAM write outside push or swap");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_PUSH && !full) |=> top_reg == $past(top_reg) + CNT_W'(1))
        else $error("push did not grow the stack");

    a_err_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STS_OK) |-> m_data == '0)
        else $error("error transaction carries data");

    a_swap_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP) |=> (state_reg == ST_SWAP_WB))
        else $error("swap write-back skipped");

endmodule
`default_nettype wire

[hw/rtl/vmos_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vmos_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module vmos_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire
